@@ rtl/gbcr_pkg.sv @@
// ----------------------------------------------------------------------------
// gbcr_pkg
// Shared types and constants for the GF(2) boundary column reducer.
// ----------------------------------------------------------------------------
package gbcr_pkg;

	localparam int DATA_W = 64;
	localparam int LOW_W  = 6;
	localparam int IDX_OUT_W = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL
	} gbcr_state_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] index;
		logic                 empty;
		logic [LOW_W-1:0]     low;
		logic [DATA_W-1:0]    bits;
		logic                 over;
	} gbcr_res_t;

endpackage

@@ rtl/gbcr_store.sv @@
// ----------------------------------------------------------------------------
// gbcr_store
// Column store: one entry per reduced column {nonempty, low, bits}, one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module gbcr_store import gbcr_pkg::*; #(
	parameter int COLS = 256,
	parameter int ROWS = 64
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(COLS)-1:0]     wr_addr,
	input  logic [ROWS+LOW_W:0]         wr_data,
	input  logic                        rd_en,
	input  logic [$clog2(COLS)-1:0]     rd_addr,
	output logic [ROWS+LOW_W:0]         rd_data
);

	logic [ROWS+LOW_W:0] mem [COLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/gbcr_reduce.sv @@
// ----------------------------------------------------------------------------
// gbcr_reduce
// Sequencer and datapath: streams the stored columns of the current matrix
// out of the store, XORs matching ones into the working column, then finds
// the low row, presents the result and writes it back unless the store is full.
// ----------------------------------------------------------------------------
module gbcr_reduce import gbcr_pkg::*; #(
	parameter int COLS = 256,
	parameter int ROWS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ROWS-1:0]             in_bits,
	input  logic                        in_last,
	output logic                        wr_en,
	output logic [$clog2(COLS)-1:0]     wr_addr,
	output logic [ROWS+LOW_W:0]         wr_data,
	output logic                        rd_en,
	output logic [$clog2(COLS)-1:0]     rd_addr,
	input  logic [ROWS+LOW_W:0]         rd_data,
	output logic                        res_valid,
	input  logic                        res_ready,
	output gbcr_res_t                   res
);

	localparam int IDX_W  = $clog2(COLS);
	localparam int CNT_W  = $clog2(COLS + 1);
	localparam int RIDX_W = $clog2(ROWS);

	gbcr_state_t      state_q, state_d;
	logic [ROWS-1:0]  v_q, v_next;
	logic             last_q;
	logic [CNT_W-1:0] n_q, cnt_q, iss_q;
	logic             pend_q;

	logic             ent_ne, hit, over, empty, accept, done;
	logic [LOW_W-1:0] ent_low, low;
	logic [ROWS-1:0]  ent_bits;

	// binary search for the top set bit, six halving steps
	function automatic logic [LOW_W-1:0] top_row(input logic [DATA_W-1:0] x);
		logic [DATA_W-1:0] w;
		logic [LOW_W-1:0]  r;
		w = x;
		r = '0;
		for (int k = LOW_W - 1; k >= 0; k--) begin
			if ((w >> (1 << k)) != '0) begin
				r[k] = 1'b1;
				w    = w >> (1 << k);
			end
		end
		return r;
	endfunction

	assign ent_bits = rd_data[ROWS-1:0];
	assign ent_low  = rd_data[ROWS+LOW_W-1:ROWS];
	assign ent_ne   = rd_data[ROWS+LOW_W];
	assign hit      = pend_q && ent_ne && v_q[ent_low[RIDX_W-1:0]];
	assign v_next   = hit ? (v_q ^ ent_bits) : v_q;

	assign empty = (v_q == '0);
	assign low   = top_row(DATA_W'(v_q));
	assign over  = (n_q == CNT_W'(COLS));

	assign res.index = IDX_OUT_W'(n_q);
	assign res.empty = empty;
	assign res.low   = low;
	assign res.bits  = DATA_W'(v_q);
	assign res.over  = over;

	assign wr_addr = n_q[IDX_W-1:0];
	assign wr_data = {~empty, low, v_q};
	assign rd_addr = iss_q[IDX_W-1:0];

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		res_valid = 1'b0;
		wr_en     = 1'b0;
		accept    = 1'b0;
		done      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = (cnt_q == '0) ? ST_FINAL : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = (iss_q != n_q);
				if (iss_q == n_q && pend_q) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				res_valid = 1'b1;
				if (res_ready) begin
					done    = 1'b1;
					wr_en   = ~over;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			iss_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= rd_en;
			if (accept) begin
				iss_q <= '0;
			end else if (rd_en) begin
				iss_q <= iss_q + 1'b1;
			end
			if (done) begin
				if (last_q) begin
					cnt_q <= '0;
				end else if (!over) begin
					cnt_q <= n_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q    <= in_bits;
			last_q <= in_last;
			n_q    <= cnt_q;
		end else if (state_q == ST_SCAN) begin
			v_q <= v_next;
		end
	end

endmodule

@@ rtl/gf2_boundary_column_reduction.sv @@
// ----------------------------------------------------------------------------
// gf2_boundary_column_reduction
// Column-at-a-time GF(2) boundary matrix reduction with a column store.
// ----------------------------------------------------------------------------
// Per column, after the transfer: one store read per stored column, a drain of
// the read pipe (both skipped when n is zero, n being the columns stored so far,
// 0..COLS), then low/write-back, then idle with s_tready high for the next column.
// The result shows on m_tvalid the cycle after write-back; the output register
// holds it so the next column may be taken while it waits.
// Reset clears the column count and control; the store is not cleared.
module gf2_boundary_column_reduction import gbcr_pkg::*; #(
	parameter int COLS = 256,
	parameter int ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] column_bits
	input  logic        s_tlast,   // end_of_matrix
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [7:0] column_index, [13:8] low_row, [77:14] reduced_bits
	output logic [1:0]  m_tuser    // [0] is_empty, [1] overflow
);

	localparam int IDX_W = $clog2(COLS);

	logic                   wr_en, rd_en, res_valid, res_ready;
	logic [IDX_W-1:0]       wr_addr, rd_addr;
	logic [ROWS+LOW_W:0]    wr_data, rd_data;
	gbcr_res_t              res;

	logic                   m_tvalid_q;
	gbcr_res_t              out_q;

	gbcr_store #(.COLS(COLS), .ROWS(ROWS)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	gbcr_reduce #(.COLS(COLS), .ROWS(ROWS)) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_bits   (s_tdata[ROWS-1:0]),
		.in_last   (s_tlast),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = ~m_tvalid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_q.bits, out_q.low, out_q.index};
	assign m_tuser  = {out_q.over, out_q.empty};

endmodule

@@ rtl/gbcr_check.sv @@
// ----------------------------------------------------------------------------
// gbcr_check
// Port-level checks for the column reducer, bound to the top level.
// ----------------------------------------------------------------------------
module gbcr_check #(
	parameter int COLS = 256
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one column in flight
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while column in progress");

	// empty column carries no bits and low row zero
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[13:8] == 6'd0 && m_tdata[77:14] == 64'd0)
		else $error("empty result with bits set");

	// low row is the top set bit of a non-empty column
	a_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[77:14] >> m_tdata[13:8]) == 64'd1)
		else $error("low row mismatch");

	// overflow only once the store is full
	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[7:0] == 8'(COLS))
		else $error("overflow below capacity");

endmodule

bind gf2_boundary_column_reduction gbcr_check #(.COLS(COLS)) u_check (.*);

@@ sim/gf2_boundary_column_reduction_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf2_boundary_column_reduction_tb
// Self-checking bench for the GF(2) boundary column reducer. Columns go in on
// the slave stream and each reduced column coming out is compared field by
// field with its table entry or a behavioural reduction of the same stream.
// A short directed table comes first, then random matrices, mostly small, with
// two that run past the store capacity. Both sides idle and stall in bursts.
// ----------------------------------------------------------------------------
module gf2_boundary_column_reduction_tb import gbcr_pkg::*;;

	localparam int COLS = 256;
	localparam int ROWS = 64;
	localparam int RANDOM_COLUMNS = 1400;
	localparam int CALM_AFTER = 1250;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int LONG_HOLD = 3000;
	localparam logic [63:0] ROW_MASK = (ROWS >= 64) ? '1 : ((64'd1 << ROWS) - 64'd1);

	typedef struct {
		logic [63:0] col;
		logic        last;
		bit          typed;
		gbcr_res_t   want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;

	// behavioural copy of the column store
	logic [63:0] store_bits [COLS];
	logic [5:0]  store_low [COLS];
	logic        store_live [COLS];
	int          stored_cnt = 0;

	gbcr_res_t   pending_results [$];
	stim_row_t   stim_rows [$];
	logic [63:0] matrix_cols [$];
	int          mismatch_cnt = 0;
	int          random_sent = 0;
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;
	int          cycles = 0;

	gf2_boundary_column_reduction #(
		.COLS(COLS),
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	function automatic gbcr_res_t reduce_column(input logic [63:0] col, input logic last);
		gbcr_res_t   r;
		logic [63:0] v;
		int          n;
		v = col & ROW_MASK;
		n = (stored_cnt > COLS) ? COLS : stored_cnt;
		for (int i = 0; i < n; i++) begin
			if (store_live[i] && v[store_low[i]])
				v ^= store_bits[i];
		end
		r.index = n[7:0];
		r.empty = (v == '0);
		r.low = '0;
		for (int b = 0; b < 64; b++) begin
			if (v[b])
				r.low = b[5:0];
		end
		r.bits = v;
		r.over = (n >= COLS);
		if (!r.over) begin
			store_bits[n] = v;
			store_low[n] = r.low;
			store_live[n] = !r.empty;
			stored_cnt = n + 1;
		end else begin
			stored_cnt = COLS;
		end
		if (last)
			stored_cnt = 0;
		return r;
	endfunction

	function automatic logic [63:0] make_column();
		logic [63:0] v;
		int          span;
		int          pick;
		v = '0;
		pick = $urandom_range(0, 9);
		if (pick >= 4 && pick <= 5 && matrix_cols.size() >= 2) begin
			// sum of earlier columns: reduces to nothing while all of them were stored
			repeat ($urandom_range(2, 3))
				v ^= matrix_cols[$urandom_range(0, matrix_cols.size() - 1)];
		end else if (pick == 6) begin
			v = '0;
		end else if (pick == 7) begin
			v = {$urandom, $urandom};
		end else if (pick == 8) begin
			v[$urandom_range(0, 63)] = 1'b1;
		end else if (pick == 9) begin
			v = $urandom_range(0, 1) ? '1 : {1'b1, 31'($urandom), $urandom};
		end else begin
			span = $urandom_range(0, 1) ? 16 : 64;
			repeat ($urandom_range(2, 3))
				v[$urandom_range(0, span - 1)] = 1'b1;
		end
		return v;
	endfunction

	task automatic add_row(input logic [63:0] col, input logic last, input bit typed,
			input logic [7:0] idx, input logic empty, input logic [5:0] low,
			input logic [63:0] bits, input logic over);
		stim_row_t row;
		row.col = col;
		row.last = last;
		row.typed = typed;
		row.want.index = idx;
		row.want.empty = empty;
		row.want.low = low;
		row.want.bits = bits;
		row.want.over = over;
		stim_rows.insert(stim_rows.size(), row);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	task automatic offer_column(input logic [63:0] col, input logic last, input bit typed,
			input gbcr_res_t want);
		gbcr_res_t pred;
		s_tvalid <= 1'b1;
		s_tdata <= col;
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		pred = reduce_column(col, last);
		pending_results.insert(pending_results.size(), typed ? want : pred);
	endtask

	task automatic idle_gap(input int n);
		s_tvalid <= 1'b0;
		s_tdata <= {$urandom, $urandom};
		s_tlast <= 1'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic check_result();
		gbcr_res_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("unexpected transfer", m_tdata[63:0], '0);
		end else begin
			want = pending_results.pop_front();
			if (m_tdata[7:0] !== want.index)
				report_mismatch("column_index", 64'(m_tdata[7:0]), 64'(want.index));
			if (m_tuser[0] !== want.empty)
				report_mismatch("is_empty", 64'(m_tuser[0]), 64'(want.empty));
			if (m_tdata[13:8] !== want.low)
				report_mismatch("low_row", 64'(m_tdata[13:8]), 64'(want.low));
			if (m_tdata[77:14] !== want.bits)
				report_mismatch("reduced_bits", m_tdata[77:14], want.bits);
			if (m_tuser[1] !== want.over)
				report_mismatch("overflow", 64'(m_tuser[1]), 64'(want.over));
		end
	endtask

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int  stall_left;
		bit  hold_done;
		bit  stall_mode;
		stall_left = 0;
		hold_done = 1'b0;
		stall_mode = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_result();
			if ($urandom_range(0, 199) == 0)
				stall_mode = !stall_mode;
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && stall_mode && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[gf2_boundary_column_reduction] ERROR");
		$finish;
	end

	initial begin
		gbcr_res_t   none;
		logic [63:0] col;
		logic        last;
		int          mat;
		int          mat_size;
		bit          idle_mode;
		none = '0;
		mat = 0;
		idle_mode = 1'b1;

		// first matrix straight after reset
		add_row(64'h0, 1'b0, 1'b1, 8'd0, 1'b1, 6'd0, 64'h0, 1'b0);
		add_row('1, 1'b0, 1'b1, 8'd1, 1'b0, 6'd63, '1, 1'b0);
		add_row(64'h1, 1'b0, 1'b1, 8'd2, 1'b0, 6'd0, 64'h1, 1'b0);
		add_row('1, 1'b1, 1'b1, 8'd3, 1'b1, 6'd0, 64'h0, 1'b0);
		// index restarts after the end mark
		add_row(64'h8000_0000_0000_0000, 1'b0, 1'b1, 8'd0, 1'b0, 6'd63,
			64'h8000_0000_0000_0000, 1'b0);
		add_row(64'h1, 1'b1, 1'b1, 8'd1, 1'b0, 6'd0, 64'h1, 1'b0);
		// triangle edges, third one cancels
		add_row(64'h3, 1'b0, 1'b0, '0, '0, '0, '0, '0);
		add_row(64'h6, 1'b0, 1'b0, '0, '0, '0, '0, '0);
		add_row(64'h5, 1'b0, 1'b0, '0, '0, '0, '0, '0);
		add_row(64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, '0, '0, '0, '0, '0);
		add_row(64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, '0, '0, '0, '0, '0);
		add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0, '0, '0, '0, '0);
		add_row(64'h5555_5555_5555_5555, 1'b1, 1'b0, '0, '0, '0, '0, '0);
		// single-column matrix
		add_row(64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 8'd0, 1'b0, 6'd56,
			64'h0123_4567_89AB_CDEF, 1'b0);
		add_row(64'h4000_0000_0000_0001, 1'b0, 1'b0, '0, '0, '0, '0, '0);
		add_row(64'h4000_0000_0000_0000, 1'b0, 1'b0, '0, '0, '0, '0, '0);
		add_row(64'h0000_0000_0000_0001, 1'b1, 1'b0, '0, '0, '0, '0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[i]) begin
			offer_column(stim_rows[i].col, stim_rows[i].last, stim_rows[i].typed,
				stim_rows[i].want);
			if ($urandom_range(0, 2) == 0)
				idle_gap($urandom_range(1, 11));
		end

		while (random_sent < RANDOM_COLUMNS) begin
			// two matrices overrun the store, the rest stay small
			mat_size = (mat == 5 || mat == 30) ? COLS + 4 : $urandom_range(1, 24);
			matrix_cols.delete();
			for (int c = 0; c < mat_size; c++) begin
				col = make_column();
				last = (c == mat_size - 1);
				matrix_cols.insert(matrix_cols.size(), col);
				offer_column(col, last, 1'b0, none);
				random_sent++;
				if (random_sent == 300)
					hold_req = 1'b1;
				if (random_sent >= CALM_AFTER)
					calm = 1'b1;
				if ($urandom_range(0, 63) == 0)
					idle_mode = !idle_mode;
				if (random_sent == 600) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (pending_results.size() != 0)
						@(posedge clk);
				end else if (!calm && idle_mode && $urandom_range(0, 3) == 0) begin
					idle_gap($urandom_range(1, 11));
				end
			end
			mat++;
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0) begin
			$display("[gf2_boundary_column_reduction] OK");
		end else begin
			$display("[gf2_boundary_column_reduction] ERROR");
		end
		$finish;
	end

endmodule
